// ===== rtl/spb_pkg.sv =====
// Shared types, codes and helpers for the sprite pixel blender.
// No dependencies; imported by spb_mix and sprite_pixel_blender.
`default_nettype none

package spb_pkg;

  // blend_mode register codes
  localparam logic [2:0] MODE_COPY   = 3'd0;
  localparam logic [2:0] MODE_CUTOUT = 3'd1;
  localparam logic [2:0] MODE_ALPHA  = 3'd2;
  localparam logic [2:0] MODE_ADD    = 3'd3;
  localparam logic [2:0] MODE_MUL    = 3'd4;
  localparam logic [2:0] MODE_LUMA   = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_BLEND_MODE = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_X   = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_Y   = 2'd2;

  localparam logic [7:0] FULL_SCALE = 8'd255;

  typedef enum logic [1:0] {
    MIX_PASS,
    MIX_ADD,
    MIX_PROD
  } mix_op_t;

  // per-channel control, decoded once from blend_mode
  typedef struct packed {
    mix_op_t op;
    logic    luma;  // weight is the source channel instead of alpha
    logic    mul;   // plain product src*dst
  } mix_ctrl_t;

  // floor(x / 255) for x <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/spb_mix.sv =====
// One color channel of the blender: pass, saturating add or weighted product / 255.
// Depends on spb_pkg.
`default_nettype none

module spb_mix
  import spb_pkg::*;
(
  input  wire mix_ctrl_t  ctrl,
  input  wire logic [7:0] src,
  input  wire logic [7:0] dst,
  input  wire logic [7:0] alpha,
  output logic      [7:0] result
);

  logic [7:0]  w;
  logic [7:0]  ma;
  logic [7:0]  mb;
  logic [15:0] prod;
  logic [8:0]  sum;
  logic [7:0]  sat;

  always_comb begin
    w    = ctrl.luma ? src : alpha;
    ma   = ctrl.mul ? dst : w;
    mb   = ctrl.mul ? 8'd0 : (FULL_SCALE - w);
    // both terms together never exceed 255*255
    prod = (16'(src) * 16'(ma)) + (16'(dst) * 16'(mb));
    sum  = {1'b0, src} + {1'b0, dst};
    sat  = sum[8] ? FULL_SCALE : sum[7:0];
  end

  always_comb begin
    case (ctrl.op)
      MIX_PASS: result = src;
      MIX_ADD:  result = sat;
      MIX_PROD: result = div255(prod);
      default:  result = src;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sprite_pixel_blender.sv =====
// Top level of the sprite pixel blender: input register, per-channel mixing, result register.
// Depends on spb_pkg and spb_mix.
`default_nettype none

// Sprite pixel blender. Takes one sprite pixel request per clock while in_stall is low and
// returns one result per request: the request lands in an input register, the three
// channel mixers and the coordinate adders work between that and the result register. With
// out_stall low the block sustains one pixel per clock; out_stall holds the result register
// and backs up into in_stall once the input register is also full. Configuration
// (blend_mode, origin_x, origin_y) is always ready and should only be written while idle.
module sprite_pixel_blender
  import spb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,

  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [11:0]        cfg_data,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [9:0]         sprite_x,
  input  wire logic [9:0]         sprite_y,
  input  wire logic [7:0]         src_red,
  input  wire logic [7:0]         src_green,
  input  wire logic [7:0]         src_blue,
  input  wire logic [7:0]         src_alpha,
  input  wire logic [7:0]         dst_red,
  input  wire logic [7:0]         dst_green,
  input  wire logic [7:0]         dst_blue,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [12:0]      out_x,
  output logic signed [12:0]      out_y,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic [7:0]              out_alpha,
  output logic                    write_enable
);

  // configuration
  logic [2:0]  blend_mode;
  logic [11:0] origin_x;
  logic [11:0] origin_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_COPY;
      origin_x   <= '0;
      origin_y   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLEND_MODE: blend_mode <= cfg_data[2:0];
        CFG_ORIGIN_X:   origin_x   <= cfg_data;
        CFG_ORIGIN_Y:   origin_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid;
  logic [9:0] s1_x;
  logic [9:0] s1_y;
  logic [7:0] s1_sr, s1_sg, s1_sb, s1_sa;
  logic [7:0] s1_dr, s1_dg, s1_db;

  logic s1_advance;
  logic in_take;

  assign s1_advance = !(out_valid && out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x  <= sprite_x;
      s1_y  <= sprite_y;
      s1_sr <= src_red;
      s1_sg <= src_green;
      s1_sb <= src_blue;
      s1_sa <= src_alpha;
      s1_dr <= dst_red;
      s1_dg <= dst_green;
      s1_db <= dst_blue;
    end
  end

  // mode decode; unused codes fall back to copy
  mix_ctrl_t ctrl;
  logic      blending;
  logic      cutout;

  always_comb begin
    ctrl     = '{op: MIX_PASS, luma: 1'b0, mul: 1'b0};
    blending = 1'b0;
    cutout   = 1'b0;
    case (blend_mode)
      MODE_CUTOUT: cutout = 1'b1;
      MODE_ALPHA: begin
        ctrl.op  = MIX_PROD;
        blending = 1'b1;
      end
      MODE_ADD: begin
        ctrl.op  = MIX_ADD;
        blending = 1'b1;
      end
      MODE_MUL: begin
        ctrl.op  = MIX_PROD;
        ctrl.mul = 1'b1;
        blending = 1'b1;
      end
      MODE_LUMA: begin
        ctrl.op   = MIX_PROD;
        ctrl.luma = 1'b1;
        blending  = 1'b1;
      end
      default: ;
    endcase
  end

  logic [7:0] red_next, green_next, blue_next;

  spb_mix u_mix_red (
    .ctrl(ctrl), .src(s1_sr), .dst(s1_dr), .alpha(s1_sa), .result(red_next)
  );

  spb_mix u_mix_green (
    .ctrl(ctrl), .src(s1_sg), .dst(s1_dg), .alpha(s1_sa), .result(green_next)
  );

  spb_mix u_mix_blue (
    .ctrl(ctrl), .src(s1_sb), .dst(s1_db), .alpha(s1_sa), .result(blue_next)
  );

  logic signed [12:0] x_next, y_next;

  always_comb begin
    x_next = $signed({3'b000, s1_x}) + $signed({origin_x[11], origin_x});
    y_next = $signed({3'b000, s1_y}) + $signed({origin_y[11], origin_y});
  end

  // result register
  logic out_load;
  assign out_load = s1_valid && s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x        <= x_next;
      out_y        <= y_next;
      out_red      <= red_next;
      out_green    <= green_next;
      out_blue     <= blue_next;
      out_alpha    <= blending ? FULL_SCALE : s1_sa;
      write_enable <= !(cutout && (s1_sa == 8'd0));
    end
  end

  // a suppressed write only ever comes from a transparent cutout pixel
  a_we_low_transparent: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (out_alpha == 8'd0)
  ) else $error("write_enable low with nonzero alpha");

  // input register only backs up when the result register is held
  a_stall_cause: assert property (
    @(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall)
  ) else $error("in_stall without downstream stall");

  // a pending request moves into the result register when not blocked
  a_advance: assert property (
    @(posedge clk) disable iff (rst)
    (s1_valid && !(out_valid && out_stall)) |=> out_valid
  ) else $error("request lost between stages");

endmodule

`default_nettype wire
